@@ rtl/atre_pkg.sv @@
`timescale 1ns / 1ps

package atre_pkg;

    // Request kinds on the slave tuser field
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // End reasons
    typedef enum logic [1:0] {
        REASON_OK      = 2'd0,
        REASON_ERROR   = 2'd1,
        REASON_TIMEOUT = 2'd2,
        REASON_FULL    = 2'd3
    } t_reason;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT  = 2'd0,
        CFG_QUIET    = 2'd1,
        CFG_CAPACITY = 2'd2
    } t_cfg_idx;

    localparam int          HIST_LEN       = 9;
    localparam int          DEF_MAX_BUFFER = 4096;
    localparam int          CAP_LIMIT      = 4096;
    localparam logic [31:0] RST_TIMEOUT    = 32'd1000;
    localparam logic [15:0] RST_QUIET      = 16'd80;
    localparam logic [12:0] RST_CAPACITY   = 13'd256;

    // CR LF ERROR CR LF, oldest byte first
    localparam logic [7:0] TERM_ERR [HIST_LEN] = '{
        8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A
    };

    // CR LF OK CR LF aligned to the newest end of the history
    localparam logic [7:0] TERM_OK [HIST_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A
    };
    localparam logic [HIST_LEN-1:0] TERM_OK_MASK = 9'b1_1111_1000;

endpackage

@@ rtl/atre_cell.sv @@
`timescale 1ns / 1ps

// One history slot: takes its neighbour's byte on a shift and flags whether
// the byte it is about to hold matches its terminator characters.
module atre_cell #(
    parameter logic       P_OK_USE  = 1'b0,
    parameter logic [7:0] P_OK_CHR  = 8'h00,
    parameter logic [7:0] P_ERR_CHR = 8'h00
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_shift,
    input  logic [7:0] i_din,
    output logic [7:0] o_q,
    output logic       o_ok_hit,
    output logic       o_err_hit
);

    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_din;
        end
    end

    assign o_q       = r_q;
    assign o_ok_hit  = !P_OK_USE || (i_din == P_OK_CHR);
    assign o_err_hit = (i_din == P_ERR_CHR);

endmodule

@@ rtl/at_response_end_detector.sv @@
`timescale 1ns / 1ps

// Channel   | Dir | Fields (lowest bit up)
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | tuser: req_type[1:0]; tdata: rx_byte[7:0]
// m_axis    | out | tuser: byte_valid; tdata: byte_out, byte_index, done_res,
//           |     |        end_reason, byte_count (35 bits, zero padded to 40)
// i_cfg     | in  | write: 0 timeout_limit, 1 quiet_limit, 2 buffer_capacity
//
// One transfer per cycle in while the result stream is not stalled, one result
// per transfer out; the result is registered and appears in the cycle after the transfer is taken.
// The nine-byte history is a row of cells; the terminator compare is done on
// the bytes being shifted in, so the flags are ready with the byte.
// s_axis_tready is high while the result register is empty or being emptied.
// i_rst_n is synchronous; it reloads the registers and opens an empty read.
module at_response_end_detector #(
    parameter int MAX_BUFFER = atre_pkg::DEF_MAX_BUFFER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] byte_out, [19:8] byte_index,
                                        // [20] done_res, [22:21] end_reason,
                                        // [34:23] byte_count, rest zero
    output logic [0:0]  m_axis_tuser    // [0] byte_valid
);

    localparam int HL = atre_pkg::HIST_LEN;
    // usable buffer ceiling: the parameter, but no more than the index allows
    localparam int CAP_TOP_I = (MAX_BUFFER > atre_pkg::CAP_LIMIT) ?
                               atre_pkg::CAP_LIMIT : MAX_BUFFER;
    localparam logic [12:0] CAP_TOP = 13'(CAP_TOP_I);

    // ---------------- configuration registers ----------------
    logic [31:0] r_timeout;
    logic [15:0] r_quiet_lim;
    logic [12:0] r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= atre_pkg::RST_TIMEOUT;
            r_quiet_lim <= atre_pkg::RST_QUIET;
            r_capacity  <= atre_pkg::RST_CAPACITY;
        end else if (i_cfg_we) begin
            unique case (atre_pkg::t_cfg_idx'(i_cfg_idx))
                atre_pkg::CFG_TIMEOUT:  r_timeout   <= i_cfg_wdata;
                atre_pkg::CFG_QUIET:    r_quiet_lim <= i_cfg_wdata[15:0];
                atre_pkg::CFG_CAPACITY: r_capacity  <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // ---------------- transfer decode ----------------
    logic             w_acc;
    atre_pkg::t_req   w_req;
    logic             w_start, w_byte, w_tick;

    logic                          r_ok_seen, r_err_seen, r_finished;
    atre_pkg::t_reason             r_reason;
    logic [31:0]                   r_elapsed;
    logic [15:0]                   r_quiet;
    logic [11:0]                   r_collected;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_req   = atre_pkg::t_req'(s_axis_tuser);
    assign w_start = w_acc && (w_req == atre_pkg::REQ_START);
    assign w_byte  = w_acc && (w_req == atre_pkg::REQ_BYTE) && !r_finished;
    assign w_tick  = w_acc && (w_req == atre_pkg::REQ_TICK) && !r_finished;

    // ---------------- history: row of cells ----------------
    logic [7:0]    w_hist [HL];
    logic [7:0]    w_feed [HL];
    logic [HL-1:0] w_ok_hit, w_err_hit;

    for (genvar g = 0; g < HL; g++) begin : g_cell
        if (g == HL - 1) begin : g_head
            assign w_feed[g] = s_axis_tdata;   // newest byte enters here
        end else begin : g_body
            assign w_feed[g] = w_hist[g+1];
        end
        atre_cell #(
            .P_OK_USE  (atre_pkg::TERM_OK_MASK[g]),
            .P_OK_CHR  (atre_pkg::TERM_OK[g]),
            .P_ERR_CHR (atre_pkg::TERM_ERR[g])
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_start),
            .i_shift   (w_byte),
            .i_din     (w_feed[g]),
            .o_q       (w_hist[g]),
            .o_ok_hit  (w_ok_hit[g]),
            .o_err_hit (w_err_hit[g])
        );
    end

    // ---------------- collection state ----------------
    logic [12:0]       w_cap_eff, w_cap_m1;
    logic              n_ok_seen, n_err_seen, n_finished;
    atre_pkg::t_reason n_reason;
    logic [31:0]       n_elapsed;
    logic [15:0]       n_quiet;
    logic [11:0]       n_collected;

    always_comb begin
        // clamp capacity into 2 .. ceiling
        if (r_capacity > CAP_TOP) begin
            w_cap_eff = CAP_TOP;
        end else if (r_capacity < 13'd2) begin
            w_cap_eff = 13'd2;
        end else begin
            w_cap_eff = r_capacity;
        end
        w_cap_m1 = w_cap_eff - 13'd1;

        n_ok_seen   = r_ok_seen;
        n_err_seen  = r_err_seen;
        n_finished  = r_finished;
        n_reason    = r_reason;
        n_elapsed   = r_elapsed;
        n_quiet     = r_quiet;
        n_collected = r_collected;

        if (w_start) begin
            n_ok_seen   = 1'b0;
            n_err_seen  = 1'b0;
            n_finished  = 1'b0;
            n_reason    = atre_pkg::REASON_OK;
            n_elapsed   = '0;
            n_quiet     = '0;
            n_collected = '0;
        end else if (w_byte || w_tick) begin
            if (w_byte) begin
                n_collected = r_collected + 12'd1;
                n_ok_seen   = r_ok_seen  || (&w_ok_hit);
                n_err_seen  = r_err_seen || (&w_err_hit);
                n_quiet     = '0;
            end else begin
                // saturating millisecond counters
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 32'd1;
                end
                if (r_quiet != '1) begin
                    n_quiet = r_quiet + 16'd1;
                end
            end
            // end checks, in priority order
            priority if ((n_ok_seen || n_err_seen) && (n_quiet >= r_quiet_lim)) begin
                n_finished = 1'b1;
                n_reason   = n_ok_seen ? atre_pkg::REASON_OK : atre_pkg::REASON_ERROR;
            end else if (n_elapsed >= r_timeout) begin
                n_finished = 1'b1;
                n_reason   = atre_pkg::REASON_TIMEOUT;
            end else if ({1'b0, n_collected} >= w_cap_m1) begin
                n_finished = 1'b1;
                n_reason   = atre_pkg::REASON_FULL;
            end else begin
                // read stays open
                n_finished = r_finished;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_seen   <= 1'b0;
            r_err_seen  <= 1'b0;
            r_finished  <= 1'b0;
            r_reason    <= atre_pkg::REASON_OK;
            r_elapsed   <= '0;
            r_quiet     <= '0;
            r_collected <= '0;
        end else begin
            r_ok_seen   <= n_ok_seen;
            r_err_seen  <= n_err_seen;
            r_finished  <= n_finished;
            r_reason    <= n_reason;
            r_elapsed   <= n_elapsed;
            r_quiet     <= n_quiet;
            r_collected <= n_collected;
        end
    end

    // ---------------- result register ----------------
    logic        r_out_valid;
    logic        r_byte_valid;
    logic [34:0] r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_acc || (r_out_valid && !m_axis_tready);
        end
    end

    // payload only moves on an accepted transfer
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byte_valid <= w_byte;
            r_out_data   <= {n_collected,
                             n_finished ? n_reason : atre_pkg::REASON_OK,
                             n_finished,
                             w_byte ? r_collected : 12'd0,
                             w_byte ? s_axis_tdata : 8'd0};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};
    assign m_axis_tuser  = r_byte_valid;

`ifndef SYNTHESIS
    // a reason other than OK only exists once the read has ended
    a_reason_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> (r_reason == atre_pkg::REASON_OK))
        else $error("end reason set on an open read");

    // a finished read ignores bytes and ticks
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_finished && (w_req != atre_pkg::REQ_START))
        |=> ($stable(r_collected) && r_finished && $stable(r_reason)))
        else $error("finished read changed state");

    // a start transfer reopens an empty read
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> ((r_collected == 12'd0) && !r_finished && !r_ok_seen && !r_err_seen))
        else $error("start did not clear the read");
`endif

endmodule
